### sv/ctl_pkg.sv
`timescale 1ns / 1ps
package ctl_pkg;

  localparam logic [6:0] KIND_INVALID = 7'd0;
  localparam logic [6:0] KIND_LIT     = 7'd40;
  localparam logic [6:0] KIND_IDENT   = 7'd41;
  localparam logic [6:0] KIND_KW0     = 7'd42;
  localparam logic [6:0] KIND_END     = 7'd67;
  localparam int         NUM_KW       = 25;
  localparam int         KW_CHARS     = 13;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PUNCT = 2'd1,
    MODE_NUM   = 2'd2,
    MODE_IDENT = 2'd3
  } lex_mode_t;

  // One emitted token
  typedef struct packed {
    logic [6:0]  kind;
    logic [31:0] start;
    logic [15:0] length;
  } tok_t;

  // Keyword text, first character in the low byte
  typedef logic [KW_CHARS*8-1:0] kw_text_t;

  function automatic kw_text_t kw_text(input int idx);
    kw_text_t t;
    string s;
    t = '0;
    case (idx)
      0: s = "auto";      1: s = "break";    2: s = "char";      3: s = "const";
      4: s = "continue";  5: s = "do";       6: s = "else";      7: s = "for";
      8: s = "if";        9: s = "int";      10: s = "long";     11: s = "print";
      12: s = "register"; 13: s = "restrict"; 14: s = "return";  15: s = "signed";
      16: s = "short";    17: s = "static";  18: s = "struct";
      19: begin
        // Storage-class keyword, built from its two halves
        s = "_Thread";
        s = {s, "_local"};
      end
      20: s = "typedef"; 21: s = "unsigned";
      22: s = "void";     23: s = "volatile"; default: s = "while";
    endcase
    for (int i = 0; i < KW_CHARS; i++) begin
      if (i < s.len()) t[i*8 +: 8] = s[i];
    end
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input int idx);
    logic [3:0] l;
    case (idx)
      5, 8: l = 4'd2;
      7, 9: l = 4'd3;
      0, 2, 6, 10, 22: l = 4'd4;
      1, 3, 11, 16, 24: l = 4'd5;
      14, 15, 17, 18: l = 4'd6;
      20: l = 4'd7;
      19: l = 4'd13;
      default: l = 4'd8;
    endcase
    return l;
  endfunction

  function automatic logic [6:0] single_kind(input logic [7:0] c);
    logic [6:0] k;
    case (c)
      8'h2e: k = 7'd1;  8'h28: k = 7'd2;  8'h29: k = 7'd3;
      8'h5b: k = 7'd4;  8'h5d: k = 7'd5;  8'h7b: k = 7'd6;
      8'h7d: k = 7'd7;  8'h2c: k = 7'd8;  8'h3b: k = 7'd9;
      8'h5e: k = 7'd10; 8'h21: k = 7'd11;
      default: k = KIND_INVALID;
    endcase
    return k;
  endfunction

  function automatic logic [6:0] lead_kind(input logic [7:0] c);
    logic [6:0] k;
    case (c)
      8'h26: k = 7'd12; 8'h7c: k = 7'd15; 8'h2b: k = 7'd18;
      8'h2d: k = 7'd21; 8'h2a: k = 7'd24; 8'h2f: k = 7'd26;
      8'h25: k = 7'd28; 8'h3d: k = 7'd30; 8'h3c: k = 7'd32;
      8'h3e: k = 7'd35; 8'h23: k = 7'd38;
      default: k = KIND_INVALID;
    endcase
    return k;
  endfunction

  function automatic logic [6:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
    logic [6:0] k;
    logic eq, dbl;
    eq  = (c == 8'h3d);
    dbl = (c == h);
    k = KIND_INVALID;
    case (h)
      8'h26: k = dbl ? 7'd13 : eq ? 7'd14 : KIND_INVALID;
      8'h7c: k = dbl ? 7'd16 : eq ? 7'd17 : KIND_INVALID;
      8'h2b: k = dbl ? 7'd19 : eq ? 7'd20 : KIND_INVALID;
      8'h2d: k = dbl ? 7'd22 : eq ? 7'd23 : KIND_INVALID;
      8'h2a: k = eq ? 7'd25 : KIND_INVALID;
      8'h2f: k = eq ? 7'd27 : KIND_INVALID;
      8'h25: k = eq ? 7'd29 : KIND_INVALID;
      8'h3d: k = eq ? 7'd31 : KIND_INVALID;
      8'h3c: k = eq ? 7'd33 : dbl ? 7'd34 : KIND_INVALID;
      8'h3e: k = eq ? 7'd36 : dbl ? 7'd37 : KIND_INVALID;
      8'h23: k = dbl ? 7'd39 : KIND_INVALID;
      default: k = KIND_INVALID;
    endcase
    return k;
  endfunction

endpackage

### sv/ctl_kw_match.sv
`timescale 1ns / 1ps
// Parallel compare of the buffered identifier against the keyword list
module ctl_kw_match #(
  parameter int KEYWORD_MAX_LEN = 13
) (
  input  logic [KEYWORD_MAX_LEN*8-1:0]     chars,
  input  logic [$clog2(KEYWORD_MAX_LEN+2)-1:0] count,
  output logic [6:0]                       kind
);
  localparam int CW = $clog2(KEYWORD_MAX_LEN+2);

  always_comb begin
    kind = ctl_pkg::KIND_IDENT;
    for (int i = ctl_pkg::NUM_KW - 1; i >= 0; i--) begin
      logic hit;
      ctl_pkg::kw_text_t t;
      hit = (count == CW'(ctl_pkg::kw_len(i)));
      t = ctl_pkg::kw_text(i);
      for (int j = 0; j < ctl_pkg::KW_CHARS; j++) begin
        if (j < int'(ctl_pkg::kw_len(i)) && chars[j*8 +: 8] != t[j*8 +: 8]) hit = 1'b0;
      end
      if (hit) kind = ctl_pkg::KIND_KW0 + 7'(i);
    end
  end
endmodule

### sv/c_token_lexer.sv
`timescale 1ns / 1ps
// A token enters the result queue when the byte that completes it is transferred.
// Throughput: one byte per cycle while the result queue has room; one byte may
// yield up to three tokens, drained one per cycle while out_ready is high from a
// four-entry queue, so ready follows queue room. Reset (rst_n low, synchronous)
// clears mode, offsets and the queue; identifier bytes are not reset.
module c_token_lexer #(
  parameter int OFFSET_BITS     = 16,
  parameter int KEYWORD_MAX_LEN = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_req,
  input  logic        in_final_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_kind,
  output logic [15:0] out_start_res,
  output logic [15:0] out_length,
  output logic        out_last_of_run
);
  localparam int CW = $clog2(KEYWORD_MAX_LEN + 2);
  localparam int QD = 4;

  typedef struct packed {
    ctl_pkg::tok_t tok;
    logic          last;
  } qent_t;

  ctl_pkg::lex_mode_t     mode_r, mode_nxt;
  logic [7:0]             held_r, held_nxt;
  logic [OFFSET_BITS-1:0] tstart_r, tstart_nxt, pos_r, pos_nxt, pos_inc;
  logic [CW-1:0]          icnt_r, icnt_nxt;
  logic                   splice_r, splice_nxt;
  logic [15:0]            tlen_r, tlen_nxt;
  logic [7:0]             ichars_r [KEYWORD_MAX_LEN];
  logic [KEYWORD_MAX_LEN*8-1:0] ichars_flat, ichars_nx;
  logic [6:0]             kw_kind;

  qent_t                  q_r [QD];
  logic [1:0]             rd_r, wr_r;
  logic [2:0]             cnt_r;

  ctl_pkg::tok_t          em [3];
  logic [1:0]             n_em;
  logic                   take, pop;

  always_comb begin
    for (int i = 0; i < KEYWORD_MAX_LEN; i++) ichars_flat[i*8 +: 8] = ichars_r[i];
  end

  ctl_kw_match #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_kw (
    .chars(ichars_flat), .count(icnt_r), .kind(kw_kind)
  );

  assign in_ready = (cnt_r <= 3'(QD - 3)) || (pop && cnt_r <= 3'(QD - 2));
  assign take     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign pos_inc  = pos_r + 1'b1;

  // Lexer step for one byte
  always_comb begin
    logic [7:0] c;
    logic consumed, is_dig, is_alp, is_id, is_sp;
    logic [6:0] pk;
    logic close_now;
    c = in_byte_req;
    mode_nxt = mode_r; held_nxt = held_r; tstart_nxt = tstart_r; pos_nxt = pos_r;
    icnt_nxt = icnt_r; splice_nxt = splice_r; tlen_nxt = tlen_r;
    ichars_nx = ichars_flat;
    n_em = 2'd0;
    for (int i = 0; i < 3; i++) em[i] = '0;
    consumed = 1'b0; close_now = 1'b0;
    is_dig = (c >= 8'h30 && c <= 8'h39);
    is_alp = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    is_id  = is_dig || is_alp || c == 8'h5f;
    is_sp  = c == 8'h20 || c == 8'h0a || c == 8'h09 || c == 8'h0d ||
             c == 8'h0c || c == 8'h0b;
    pk = ctl_pkg::pair_kind(held_r, c);

    if (splice_r) begin
      if (c == 8'h0a || c == 8'h0d) begin
        splice_nxt = 1'b0; consumed = 1'b1;
      end else close_now = 1'b1;
    end else if (mode_r == ctl_pkg::MODE_PUNCT) begin
      if (pk != ctl_pkg::KIND_INVALID) begin
        em[0] = '{pk, 32'(tstart_r), 16'd2}; n_em = 2'd1;
        mode_nxt = ctl_pkg::MODE_IDLE; consumed = 1'b1;
      end else close_now = 1'b1;
    end else if (mode_r == ctl_pkg::MODE_NUM || mode_r == ctl_pkg::MODE_IDENT) begin
      if ((mode_r == ctl_pkg::MODE_NUM) ? is_dig : is_id) begin
        if (mode_r == ctl_pkg::MODE_IDENT) begin
          if (icnt_r < CW'(KEYWORD_MAX_LEN)) begin
            ichars_nx[icnt_r*8 +: 8] = c;
            icnt_nxt = icnt_r + 1'b1;
          end else icnt_nxt = CW'(KEYWORD_MAX_LEN + 1);
        end
        if (tlen_r != 16'hffff) tlen_nxt = tlen_r + 1'b1;
        consumed = 1'b1;
      end else close_now = 1'b1;
    end

    // Close the open token before the byte starts anything new
    if (close_now) begin
      if (splice_r) begin
        em[0] = '{ctl_pkg::KIND_INVALID, 32'(tstart_r), 16'd1}; n_em = 2'd1;
      end else if (mode_r == ctl_pkg::MODE_PUNCT) begin
        em[0] = '{ctl_pkg::lead_kind(held_r), 32'(tstart_r), 16'd1}; n_em = 2'd1;
      end else if (mode_r == ctl_pkg::MODE_NUM) begin
        em[0] = '{ctl_pkg::KIND_LIT, 32'(tstart_r), tlen_r}; n_em = 2'd1;
      end else begin
        em[0] = '{kw_kind, 32'(tstart_r), tlen_r}; n_em = 2'd1;
      end
      splice_nxt = 1'b0; mode_nxt = ctl_pkg::MODE_IDLE;
    end

    if (!consumed) begin
      if (c == 8'h00) begin
        em[n_em] = '{ctl_pkg::KIND_END, 32'(pos_r), 16'd1}; n_em = n_em + 1'b1;
      end else if (is_sp) begin
        n_em = n_em;
      end else if (ctl_pkg::single_kind(c) != ctl_pkg::KIND_INVALID) begin
        em[n_em] = '{ctl_pkg::single_kind(c), 32'(pos_r), 16'd1}; n_em = n_em + 1'b1;
      end else if (ctl_pkg::lead_kind(c) != ctl_pkg::KIND_INVALID) begin
        mode_nxt = ctl_pkg::MODE_PUNCT; held_nxt = c; tstart_nxt = pos_r;
      end else if (is_dig) begin
        mode_nxt = ctl_pkg::MODE_NUM; tstart_nxt = pos_r; tlen_nxt = 16'd1;
      end else if (is_alp || c == 8'h5f) begin
        mode_nxt = ctl_pkg::MODE_IDENT; tstart_nxt = pos_r; tlen_nxt = 16'd1;
        ichars_nx[7:0] = c; icnt_nxt = CW'(1);
      end else if (c == 8'h5c) begin
        splice_nxt = 1'b1; tstart_nxt = pos_r;
      end else begin
        em[n_em] = '{ctl_pkg::KIND_INVALID, 32'(pos_r), 16'd1}; n_em = n_em + 1'b1;
      end
    end
    pos_nxt = pos_inc;

    // Final byte: close with the post-step state, then end of source
    if (in_final_req) begin
      if (splice_nxt) begin
        em[n_em] = '{ctl_pkg::KIND_INVALID, 32'(tstart_nxt), 16'd1}; n_em = n_em + 1'b1;
      end else if (mode_nxt == ctl_pkg::MODE_PUNCT) begin
        em[n_em] = '{ctl_pkg::lead_kind(held_nxt), 32'(tstart_nxt), 16'd1};
        n_em = n_em + 1'b1;
      end else if (mode_nxt == ctl_pkg::MODE_NUM) begin
        em[n_em] = '{ctl_pkg::KIND_LIT, 32'(tstart_nxt), tlen_nxt}; n_em = n_em + 1'b1;
      end else if (mode_nxt == ctl_pkg::MODE_IDENT) begin
        em[n_em] = '{ctl_pkg::KIND_IDENT, 32'(tstart_nxt), tlen_nxt};
        n_em = n_em + 1'b1;
      end
      if (c != 8'h00) begin
        em[n_em] = '{ctl_pkg::KIND_END, 32'(pos_inc), 16'd0}; n_em = n_em + 1'b1;
      end
      pos_nxt = '0; mode_nxt = ctl_pkg::MODE_IDLE; splice_nxt = 1'b0;
    end
  end

  // Keyword kind at end of source needs the updated buffer
  logic [6:0] kw_fin;
  logic [CW-1:0] icnt_fin;
  assign icnt_fin = icnt_nxt;
  ctl_kw_match #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_kw_fin (
    .chars(ichars_nx), .count(icnt_fin), .kind(kw_fin)
  );

  // Advance lexer state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ctl_pkg::MODE_IDLE; held_r <= '0; tstart_r <= '0; pos_r <= '0;
      icnt_r <= '0; splice_r <= 1'b0; tlen_r <= '0;
    end else if (take) begin
      mode_r <= mode_nxt; held_r <= held_nxt; tstart_r <= tstart_nxt; pos_r <= pos_nxt;
      icnt_r <= icnt_nxt; splice_r <= splice_nxt; tlen_r <= tlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < KEYWORD_MAX_LEN; i++) ichars_r[i] <= ichars_nx[i*8 +: 8];
    end
  end

  // Result queue: push up to three tokens, pop one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      logic [1:0] npush;
      npush = take ? n_em : 2'd0;
      wr_r  <= wr_r + npush;
      rd_r  <= rd_r + 2'(pop);
      cnt_r <= cnt_r + 3'(npush) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n_em) begin
          q_r[wr_r + 2'(i)].tok  <= em[i];
          q_r[wr_r + 2'(i)].last <= (2'(i) == n_em - 2'd1);
          // Final-byte identifier close uses the fresh keyword compare
          if (in_final_req && em[i].kind == ctl_pkg::KIND_IDENT &&
              mode_nxt != ctl_pkg::MODE_IDENT && 2'(i) == n_em - 2'd1 - 2'(in_byte_req != 8'h00))
            q_r[wr_r + 2'(i)].tok.kind <= kw_fin;
        end
      end
    end
  end

  assign out_valid       = cnt_r != 3'd0;
  assign out_kind        = q_r[rd_r].tok.kind;
  assign out_start_res   = q_r[rd_r].tok.start[15:0];
  assign out_length      = q_r[rd_r].tok.length;
  assign out_last_of_run = q_r[rd_r].last;
endmodule

### sv/c_token_lexer_chk.sv
`timescale 1ns / 1ps
module c_token_lexer_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  out_kind,
  input logic [15:0] out_length
);
  // Kinds stay in the defined range
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= ctl_pkg::KIND_END) else $error("kind out of range");

  // Only end tokens may have zero length
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length == 16'd0 |-> out_kind == ctl_pkg::KIND_END)
    else $error("empty non-end token");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind))
    else $error("result dropped");

  // Nothing shows right after reset, and input is open
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");
endmodule

bind c_token_lexer c_token_lexer_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
  .out_length(out_length)
);

### tb/c_token_lexer_checker.sv
`timescale 1ns / 1ps
module c_token_lexer_checker
  import ctl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte_req,
  input  logic        in_final_req,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [6:0]  out_kind,
  input  logic [15:0] out_start_res,
  input  logic [15:0] out_length,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          pending_tokens,
  output int          token_total
);

  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } lex_tok_t;

  lex_tok_t   tok_queue[$];
  lex_tok_t   step_toks[$];
  lex_mode_t  mode;
  logic [7:0] held;
  logic [15:0] tok_start;
  logic [15:0] pos;
  logic [15:0] tok_len;
  logic [7:0] word[KW_CHARS];
  int         word_len;
  logic       splice;

  function automatic logic is_digit_c(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha_c(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0a || c == 8'h09 || c == 8'h0d || c == 8'h0c ||
           c == 8'h0b;
  endfunction

  function automatic logic [6:0] word_kind();
    logic [6:0] k;
    logic       hit;
    k = KIND_IDENT;
    if (word_len <= KW_CHARS) begin
      for (int i = NUM_KW - 1; i >= 0; i--) begin
        hit = (kw_len(i) == word_len);
        for (int j = 0; j < KW_CHARS; j++)
          if (j < word_len && word[j] != kw_text(i)[j*8 +: 8]) hit = 0;
        if (hit) k = KIND_KW0 + 7'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [6:0] lead_of(input logic [7:0] c);
    case (c)
      "&": return 7'd12; "|": return 7'd15; "+": return 7'd18; "-": return 7'd21;
      "*": return 7'd24; "/": return 7'd26; "%": return 7'd28; "=": return 7'd30;
      "<": return 7'd32; ">": return 7'd35; "#": return 7'd38;
      default: return KIND_INVALID;
    endcase
  endfunction

  function automatic logic [6:0] pair_of(input logic [7:0] h, input logic [7:0] c);
    logic dbl, eq;
    dbl = (c == h);
    eq = (c == "=");
    case (h)
      "&", "|", "+", "-": return dbl ? lead_of(h) + 7'd1 : eq ? lead_of(h) + 7'd2 : 7'd0;
      "*", "/", "%", "=": return eq ? lead_of(h) + 7'd1 : 7'd0;
      "<", ">": return eq ? lead_of(h) + 7'd1 : dbl ? lead_of(h) + 7'd2 : 7'd0;
      "#": return dbl ? 7'd39 : 7'd0;
      default: return 7'd0;
    endcase
  endfunction

  task automatic emit_tok(input logic [6:0] k, input logic [15:0] s, input logic [15:0] l);
    lex_tok_t t;
    if (step_toks.size() < 3) begin
      t = '{kind: k, start: s, length: l, last: 1'b0};
      step_toks.push_back(t);
    end
  endtask

  task automatic close_token();
    if (splice) emit_tok(KIND_INVALID, tok_start, 16'd1);
    else if (mode == MODE_PUNCT) emit_tok(lead_of(held), tok_start, 16'd1);
    else if (mode == MODE_NUM) emit_tok(KIND_LIT, tok_start, tok_len);
    else if (mode == MODE_IDENT) emit_tok(word_kind(), tok_start, tok_len);
    splice = 0;
    mode = MODE_IDLE;
  endtask

  task automatic push_char(input logic [7:0] c);
    if (word_len < KW_CHARS) begin
      word[word_len] = c;
      word_len++;
    end else begin
      word_len = KW_CHARS + 1;
    end
  endtask

  // Advance the lexer by one byte and queue the tokens it completes
  task automatic lex_byte(input logic [7:0] c, input logic fin);
    logic       taken;
    logic [6:0] k;
    logic       more;
    lex_tok_t   t;
    taken = 0;
    step_toks.delete();
    if (splice) begin
      if (c == 8'h0a || c == 8'h0d) begin
        splice = 0;
        taken = 1;
      end else close_token();
    end else if (mode == MODE_PUNCT) begin
      k = pair_of(held, c);
      if (k != 0) begin
        emit_tok(k, tok_start, 16'd2);
        mode = MODE_IDLE;
        taken = 1;
      end else close_token();
    end else if (mode == MODE_NUM || mode == MODE_IDENT) begin
      more = (mode == MODE_NUM) ? is_digit_c(c) : (is_alpha_c(c) || is_digit_c(c));
      if (more) begin
        if (mode == MODE_IDENT) push_char(c);
        if (tok_len != 16'hffff) tok_len++;
        taken = 1;
      end else close_token();
    end
    if (!taken) begin
      if (c == 0) emit_tok(KIND_END, pos, 16'd1);
      else if (is_blank(c)) ;
      else if (single_kind(c) != 0) emit_tok(single_kind(c), pos, 16'd1);
      else if (lead_of(c) != 0) begin
        mode = MODE_PUNCT;
        held = c;
        tok_start = pos;
      end else if (is_digit_c(c)) begin
        mode = MODE_NUM;
        tok_start = pos;
        tok_len = 1;
      end else if (is_alpha_c(c)) begin
        mode = MODE_IDENT;
        tok_start = pos;
        tok_len = 1;
        word_len = 0;
        push_char(c);
      end else if (c == "\\") begin
        splice = 1;
        tok_start = pos;
      end else emit_tok(KIND_INVALID, pos, 16'd1);
    end
    pos++;
    if (fin) begin
      close_token();
      if (c != 0) emit_tok(KIND_END, pos, 16'd0);
      pos = 0;
    end
    for (int i = 0; i < step_toks.size(); i++) begin
      t = step_toks[i];
      t.last = (i == step_toks.size() - 1);
      tok_queue.push_back(t);
    end
  endtask

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    lex_tok_t want;
    if (!rst_n) begin
      mode = MODE_IDLE;
      held = 0;
      tok_start = 0;
      pos = 0;
      tok_len = 0;
      word_len = 0;
      splice = 0;
      fail_count = 0;
      token_total = 0;
      tok_queue.delete();
    end else begin
      if (in_valid && in_ready) lex_byte(in_byte_req, in_final_req);
      if (out_valid && out_ready) begin
        token_total++;
        if (tok_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected token kind=%0d start=%0d len=%0d", $time,
                   out_kind, out_start_res, out_length);
        end else begin
          want = tok_queue.pop_front();
          if (want.kind != out_kind || want.start != out_start_res ||
              want.length != out_length || want.last != out_last_of_run) begin
            fail_count++;
            $display("%0t: token mismatch expected kind=%0d start=%0d len=%0d last=%0b",
                     $time, want.kind, want.start, want.length, want.last);
            $display("%0t:                actual kind=%0d start=%0d len=%0d last=%0b",
                     $time, out_kind, out_start_res, out_length, out_last_of_run);
          end
        end
      end
    end
    pending_tokens = tok_queue.size();
  end

endmodule

### tb/c_token_lexer_test.sv
`timescale 1ns / 1ps
module c_token_lexer_test;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  in_byte_req = 0;
  logic        in_final_req = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [6:0]  out_kind;
  logic [15:0] out_start_res;
  logic [15:0] out_length;
  logic        out_last_of_run;
  int          fail_count;
  int          pending_tokens;
  int          token_total;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  logic        calm = 0;
  string       words[$];
  string       tl_kw;

  always #5 clk = ~clk;

  c_token_lexer dut (.*);

  c_token_lexer_checker u_checker (.*);

  // Stall the result side at random, except during the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 35);
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 200000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drive one byte and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_byte_req <= b;
    in_final_req <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && i == s.len() - 1);
  endtask

  // Emit one random token-ish fragment to the source
  task automatic random_piece();
    string p;
    int    n;
    byte   ch;
    case ($urandom_range(9))
      0, 1: p = words[$urandom_range(words.size() - 1)];
      2: begin
        p = "";
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++) begin
          ch = 8'("a" + $urandom_range(25));
          p = {p, string'(ch)};
        end
      end
      3: begin
        p = "";
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          ch = 8'("0" + $urandom_range(9));
          p = {p, string'(ch)};
        end
      end
      4: p = "&&|&=||=+++=---=*=/=%===<=<<>=>>##!^.,;()[]{}";
      5: p = $urandom_range(1) ? "\\\n" : "\\\r";
      6: p = " ";
      default: p = "";
    endcase
    if (p == "") begin
      send_byte(8'($urandom_range(255)), 0);
    end else if ($urandom_range(3) == 0 && p.len() > 2) begin
      n = $urandom_range(p.len() - 2);
      send_text(p.substr(n, n + 1), 0);
    end else send_text(p, 0);
  endtask

  initial begin
    tl_kw = "_Thread";
    tl_kw = {tl_kw, "_local"};
    words = '{"auto", "break", "char", "const", "continue", "do", "else", "for", "if",
              "int", "long", "print", "register", "restrict", "return", "signed",
              "short", "static", "struct", tl_kw, "typedef", "unsigned",
              "void", "volatile", "while", {tl_kw, "s"}, "whiles", "Int"};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: keywords, operators, splices, stray backslash, zero byte, high bytes
    send_text("int x1=0x", 0);
    send_text("<<=>>a\\\nb\\q", 0);
    send_byte(8'h00, 0);
    send_byte(8'hff, 0);
    send_text({"~", tl_kw, " 99"}, 1);
    send_text("<", 1);
    send_text("\\", 1);
    send_byte(8'h80, 0);
    send_byte(8'h00, 1);
    in_valid <= 0;

    // Let everything drain before the random part
    @(posedge clk);
    while (pending_tokens != 0) @(posedge clk);
    repeat (3) @(posedge clk);

    while (bytes_sent < 150) begin
      calm = (bytes_sent >= 70 && bytes_sent < 110);
      random_piece();
      if ($urandom_range(15) == 0) send_byte(8'h20, 1);
    end
    calm = 0;
    send_byte("x", 1);
    in_valid <= 0;

    @(posedge clk);
    while (pending_tokens != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Lexed %0d bytes into %0d tokens: keywords, operators, literals,", bytes_sent,
             token_total);
    $display("splices, stray backslashes, zero and final bytes, with random stalls.");
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
sv/ctl_pkg.sv
sv/ctl_kw_match.sv
sv/c_token_lexer.sv
sv/c_token_lexer_chk.sv
tb/c_token_lexer_checker.sv
tb/c_token_lexer_test.sv
